// ----- sv/ont_pkg.sv -----
// shared types and constants of the object notation tokenizer
// token and record layouts used by front, queue, back and top level
package ont_pkg;

  localparam int FIELD_W = 24;
  localparam int MAX_TOKENS = 3;
  localparam int COUNTER_BITS = 24;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [3:0] {
    KIND_LPAREN,
    KIND_RPAREN,
    KIND_LBRACK,
    KIND_RBRACK,
    KIND_LBRACE,
    KIND_RBRACE,
    KIND_COMMA,
    KIND_COLON,
    KIND_STRING,
    KIND_IDENT,
    KIND_END,
    KIND_ERROR
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_STRING,
    ERR_COMMENT,
    ERR_BYTE
  } err_e;

  typedef struct packed {
    kind_e              kind;
    logic [FIELD_W-1:0] offset;
    logic [FIELD_W-1:0] length;
    logic [FIELD_W-1:0] line;
    logic [FIELD_W-1:0] column;
    err_e               err;
  } token_t;

  // all tokens caused by one input word, slot 0 first
  typedef struct packed {
    logic [1:0]                  count;
    token_t [MAX_TOKENS-1:0]     tok;
  } rec_t;

endpackage

// ----- sv/ont_front.sv -----
// scanner front end: classifies each input word and updates mode and counters
// builds one record of up to three tokens per word; depends on ont_pkg
module ont_front #(
  parameter int CounterBits = ont_pkg::COUNTER_BITS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     text_byte_i,
  input  logic           final_byte_i,
  output ont_pkg::rec_t  rec_o,
  output logic           rec_valid_o
);

  localparam int FieldW = ont_pkg::FIELD_W;
  localparam logic [7:0] CharLf     = 8'h0a;
  localparam logic [7:0] CharCr     = 8'h0d;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharNul    = 8'h00;
  localparam logic [7:0] CharBslash = 8'h5c;
  localparam logic [7:0] CharStar   = 8'h2a;
  localparam logic [7:0] CharSlash  = 8'h2f;
  localparam logic [7:0] CharDquote = 8'h22;
  localparam logic [7:0] CharSquote = 8'h27;
  localparam logic [CounterBits-1:0] CntOne = CounterBits'(1);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_SLASH,
    MODE_IDENT,
    MODE_STR,
    MODE_ESC,
    MODE_CMT,
    MODE_STAR
  } mode_e;

  mode_e                  mode_q, mode_d;
  logic                   single_q, single_d;
  logic [CounterBits-1:0] pos_q, pos_d;
  logic [CounterBits-1:0] line_q, line_d;
  logic [CounterBits-1:0] col_q, col_d;
  logic [CounterBits-1:0] bofs_q, bofs_d;
  logic [CounterBits-1:0] bline_q, bline_d;
  logic [CounterBits-1:0] bcol_q, bcol_d;

  function automatic logic [CounterBits-1:0] sat_inc(input logic [CounterBits-1:0] v);
    return (v == {CounterBits{1'b1}}) ? v : v + CntOne;
  endfunction

  function automatic ont_pkg::kind_e punct_kind(input logic [7:0] c);
    ont_pkg::kind_e k;
    unique case (c)
      8'h28:   k = ont_pkg::KIND_LPAREN;
      8'h29:   k = ont_pkg::KIND_RPAREN;
      8'h5b:   k = ont_pkg::KIND_LBRACK;
      8'h5d:   k = ont_pkg::KIND_RBRACK;
      8'h7b:   k = ont_pkg::KIND_LBRACE;
      8'h7d:   k = ont_pkg::KIND_RBRACE;
      8'h2c:   k = ont_pkg::KIND_COMMA;
      8'h3a:   k = ont_pkg::KIND_COLON;
      default: k = ont_pkg::KIND_ERROR;
    endcase
    return k;
  endfunction

  function automatic ont_pkg::token_t make_tok(
    input ont_pkg::kind_e         kind,
    input logic [CounterBits-1:0] off,
    input logic [CounterBits-1:0] len,
    input logic [CounterBits-1:0] ln,
    input logic [CounterBits-1:0] col,
    input ont_pkg::err_e          err
  );
    ont_pkg::token_t t;
    t.kind   = kind;
    t.offset = FieldW'(off);
    t.length = FieldW'(len);
    t.line   = FieldW'(ln);
    t.column = FieldW'(col);
    t.err    = err;
    return t;
  endfunction

  always_comb begin
    mode_e          cur;
    logic           do_idle;
    logic [1:0]     n;
    logic [7:0]     quote;
    logic           is_space;
    logic           is_quote;
    logic           is_punct;
    ont_pkg::kind_e pk;

    mode_d   = mode_q;
    single_d = single_q;
    bofs_d   = bofs_q;
    bline_d  = bline_q;
    bcol_d   = bcol_q;
    rec_o    = '0;
    n        = 2'd0;
    do_idle  = 1'b0;
    cur      = mode_q;

    quote    = single_q ? CharSquote : CharDquote;
    is_space = (text_byte_i == CharSpace) || (text_byte_i == CharTab) ||
               (text_byte_i == CharLf) || (text_byte_i == CharCr);
    is_quote = (text_byte_i == CharDquote) || (text_byte_i == CharSquote);
    pk       = punct_kind(text_byte_i);
    is_punct = (pk != ont_pkg::KIND_ERROR);

    if (mode_q == MODE_SLASH && text_byte_i == CharStar) begin
      mode_d = MODE_CMT;
    end else begin
      if (mode_q == MODE_SLASH) begin
        cur    = MODE_IDENT;
        mode_d = MODE_IDENT;
      end
      unique case (cur)
        MODE_IDENT: begin
          if (is_punct || is_quote || is_space || text_byte_i == CharNul) begin
            rec_o.tok[n] = make_tok(ont_pkg::KIND_IDENT, bofs_q, pos_q - bofs_q,
                                    bline_q, bcol_q, ont_pkg::ERR_NONE);
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        MODE_STR: begin
          if (text_byte_i == quote) begin
            rec_o.tok[n] = make_tok(ont_pkg::KIND_STRING, bofs_q, pos_q - bofs_q,
                                    bline_q, bcol_q, ont_pkg::ERR_NONE);
            n = n + 2'd1;
            mode_d = MODE_IDLE;
          end else if (text_byte_i == CharBslash) begin
            mode_d = MODE_ESC;
          end
        end
        MODE_ESC: mode_d = MODE_STR;
        MODE_CMT: begin
          if (text_byte_i == CharStar) begin
            mode_d = MODE_STAR;
          end
        end
        MODE_STAR: begin
          if (text_byte_i == CharSlash) begin
            mode_d = MODE_IDLE;
          end else if (text_byte_i != CharStar) begin
            mode_d = MODE_CMT;
          end
        end
        default: do_idle = 1'b1;
      endcase

      // a token may start on this word
      if (do_idle) begin
        mode_d = MODE_IDLE;
        priority if (is_punct) begin
          rec_o.tok[n] = make_tok(pk, pos_q, CntOne, line_q, col_q, ont_pkg::ERR_NONE);
          n = n + 2'd1;
        end else if (is_quote) begin
          mode_d   = MODE_STR;
          single_d = (text_byte_i == CharSquote);
          bofs_d   = sat_inc(pos_q);
          bline_d  = line_q;
          bcol_d   = col_q;
        end else if (is_space) begin
          mode_d = MODE_IDLE;
        end else if (text_byte_i == CharNul) begin
          rec_o.tok[n] = make_tok(ont_pkg::KIND_ERROR, pos_q, CntOne, line_q, col_q,
                                  ont_pkg::ERR_BYTE);
          n = n + 2'd1;
        end else begin
          mode_d  = (text_byte_i == CharSlash) ? MODE_SLASH : MODE_IDENT;
          bofs_d  = pos_q;
          bline_d = line_q;
          bcol_d  = col_q;
        end
      end
    end

    pos_d = sat_inc(pos_q);
    if (text_byte_i == CharLf) begin
      line_d = sat_inc(line_q);
      col_d  = CntOne;
    end else begin
      line_d = line_q;
      col_d  = sat_inc(col_q);
    end

    // end of text
    if (final_byte_i) begin
      priority if (mode_d == MODE_STR || mode_d == MODE_ESC) begin
        rec_o.tok[n] = make_tok(ont_pkg::KIND_ERROR, bofs_d, '0, bline_d, bcol_d,
                                ont_pkg::ERR_STRING);
        n = n + 2'd1;
      end else if (mode_d == MODE_CMT || mode_d == MODE_STAR) begin
        rec_o.tok[n] = make_tok(ont_pkg::KIND_ERROR, bofs_d, '0, bline_d, bcol_d,
                                ont_pkg::ERR_COMMENT);
        n = n + 2'd1;
      end else begin
        if (mode_d == MODE_IDENT || mode_d == MODE_SLASH) begin
          rec_o.tok[n] = make_tok(ont_pkg::KIND_IDENT, bofs_d, pos_d - bofs_d,
                                  bline_d, bcol_d, ont_pkg::ERR_NONE);
          n = n + 2'd1;
        end
        rec_o.tok[n] = make_tok(ont_pkg::KIND_END, pos_d, '0, line_d, col_d,
                                ont_pkg::ERR_NONE);
        n = n + 2'd1;
      end
      mode_d   = MODE_IDLE;
      single_d = 1'b0;
      pos_d    = '0;
      line_d   = CntOne;
      col_d    = CntOne;
      bofs_d   = '0;
      bline_d  = CntOne;
      bcol_d   = CntOne;
    end

    rec_o.count = n;
  end

  assign rec_valid_o = accept_i && (rec_o.count != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      single_q <= 1'b0;
      pos_q    <= '0;
      line_q   <= CntOne;
      col_q    <= CntOne;
      bofs_q   <= '0;
      bline_q  <= CntOne;
      bcol_q   <= CntOne;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      single_q <= single_d;
      pos_q    <= pos_d;
      line_q   <= line_d;
      col_q    <= col_d;
      bofs_q   <= bofs_d;
      bline_q  <= bline_d;
      bcol_q   <= bcol_d;
    end
  end

  a_final_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && final_byte_i) |=> (mode_q == MODE_IDLE && pos_q == '0 && line_q == CntOne))
    else $error("scanner did not restart after final word");

endmodule

// ----- sv/ont_queue.sv -----
// short record queue between scanner front and token back end
// register array with one write and one read port; depends on ont_pkg
module ont_queue #(
  parameter int Depth = ont_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  ont_pkg::rec_t wr_data_i,
  input  logic          rd_i,
  output ont_pkg::rec_t rd_data_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  ont_pkg::rec_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o    = (cnt_q == CntFull);
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(wr_i) - CntW'(rd_i);
    end
  end

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o)
    else $error("record written into full queue");

  a_no_read_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> !empty_o)
    else $error("record read from empty queue");

  a_no_empty_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> (wr_data_i.count != 2'd0))
    else $error("record without tokens queued");

endmodule

// ----- sv/ont_back.sv -----
// token back end: walks the slots of the head record, one token per taken pop
// frees the record after its last token is taken; depends on ont_pkg
module ont_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ont_pkg::rec_t   head_i,
  input  logic            head_empty_i,
  input  logic            pop_i,
  output logic            head_rd_o,
  output ont_pkg::token_t tok_o,
  output logic            run_end_o
);

  logic [1:0] slot_q;
  logic       last;
  logic       take;

  assign tok_o     = head_i.tok[slot_q];
  assign last      = (slot_q == head_i.count - 2'd1);
  assign run_end_o = last;
  assign take      = pop_i && !head_empty_i;
  assign head_rd_o = take && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= 2'd0;
    end else if (take) begin
      slot_q <= last ? 2'd0 : slot_q + 2'd1;
    end
  end

  a_slot_in_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_empty_i |-> (slot_q < head_i.count))
    else $error("token slot beyond record");

endmodule

// ----- sv/object_notation_tokenizer_top.sv -----
// object notation tokenizer, top level
// depends on ont_pkg, ont_front, ont_queue, ont_back
//
// input channel: a text word (text_byte_i, final_byte_i) is taken at a clock
// edge with push high and full low. output channel: while empty is low
// the oldest token sits on the token ports and is taken at an edge with pop
// high. run_end_o marks the last token caused by one input word.
// the scanner takes one word every cycle while full is low; a word that
// completes tokens queues their record as it is taken. a word yields up to
// three tokens and the output side moves one token per cycle while pop is high, so the input
// keeps one word per cycle only while words average at most one token and
// pop stays high; a record queue of QUEUE_DEPTH entries sets how far the
// input may run ahead of the output.
// when pop stays low the queue fills and full rises; no token is lost.
// reset clears the scan mode, puts offset at 0 and line and column at 1, and
// empties the queue. after a word with final_byte_i the scanner emits the end
// token or an unclosed string or comment error, then starts over as at reset.
module object_notation_tokenizer_top #(
  parameter int COUNTER_BITS = ont_pkg::COUNTER_BITS,
  parameter int QUEUE_DEPTH  = ont_pkg::QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   text_byte_i,
  input  logic                         final_byte_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [3:0]                   token_kind_o,
  output logic [ont_pkg::FIELD_W-1:0]  start_offset_o,
  output logic [ont_pkg::FIELD_W-1:0]  token_length_o,
  output logic [ont_pkg::FIELD_W-1:0]  start_line_o,
  output logic [ont_pkg::FIELD_W-1:0]  start_column_o,
  output logic [1:0]                   error_code_o,
  output logic                         run_end_o
);

  ont_pkg::rec_t   rec;
  logic            rec_valid;
  ont_pkg::rec_t   head;
  logic            head_rd;
  logic            q_full;
  logic            q_empty;
  logic            accept;
  ont_pkg::token_t tok;

  assign accept = push && !q_full;
  assign full   = q_full;
  assign empty  = q_empty;

  ont_front #(
    .CounterBits(COUNTER_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .text_byte_i  (text_byte_i),
    .final_byte_i (final_byte_i),
    .rec_o        (rec),
    .rec_valid_o  (rec_valid)
  );

  ont_queue #(
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (rec_valid),
    .wr_data_i (rec),
    .rd_i      (head_rd),
    .rd_data_o (head),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  ont_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_empty_i (q_empty),
    .pop_i        (pop),
    .head_rd_o    (head_rd),
    .tok_o        (tok),
    .run_end_o    (run_end_o)
  );

  assign token_kind_o   = tok.kind;
  assign start_offset_o = tok.offset;
  assign token_length_o = tok.length;
  assign start_line_o   = tok.line;
  assign start_column_o = tok.column;
  assign error_code_o   = tok.err;

endmodule

// ----- bench/tb_top.sv -----
// testbench of object_notation_tokenizer_top: streams directed and random text words,
// predicts every token with its own scanner model and checks the token ports in order
// depends on ont_pkg and the tokenizer rtl
`timescale 1ns / 100ps

localparam logic [7:0] CH_NUL    = 8'h00;
localparam logic [7:0] CH_TAB    = 8'h09;
localparam logic [7:0] CH_LF     = 8'h0A;
localparam logic [7:0] CH_CR     = 8'h0D;
localparam logic [7:0] CH_SP     = 8'h20;
localparam logic [7:0] CH_DQ     = 8'h22;
localparam logic [7:0] CH_SQ     = 8'h27;
localparam logic [7:0] CH_LPAREN = 8'h28;
localparam logic [7:0] CH_RPAREN = 8'h29;
localparam logic [7:0] CH_STAR   = 8'h2A;
localparam logic [7:0] CH_COMMA  = 8'h2C;
localparam logic [7:0] CH_SLASH  = 8'h2F;
localparam logic [7:0] CH_COLON  = 8'h3A;
localparam logic [7:0] CH_LBRACK = 8'h5B;
localparam logic [7:0] CH_BSLASH = 8'h5C;
localparam logic [7:0] CH_RBRACK = 8'h5D;
localparam logic [7:0] CH_LBRACE = 8'h7B;
localparam logic [7:0] CH_RBRACE = 8'h7D;

typedef enum logic [2:0] {
  SCAN_IDLE,
  SCAN_SLASH,
  SCAN_IDENT,
  SCAN_STR,
  SCAN_ESC,
  SCAN_CMT,
  SCAN_STAR
} scan_e;

typedef struct packed {
  ont_pkg::token_t tok;
  logic            last;
} due_token_t;

function automatic bit punct_kind(input logic [7:0] c, output ont_pkg::kind_e k);
  punct_kind = 1'b1;
  k = ont_pkg::KIND_LPAREN;
  case (c)
    CH_LPAREN: k = ont_pkg::KIND_LPAREN;
    CH_RPAREN: k = ont_pkg::KIND_RPAREN;
    CH_LBRACK: k = ont_pkg::KIND_LBRACK;
    CH_RBRACK: k = ont_pkg::KIND_RBRACK;
    CH_LBRACE: k = ont_pkg::KIND_LBRACE;
    CH_RBRACE: k = ont_pkg::KIND_RBRACE;
    CH_COMMA:  k = ont_pkg::KIND_COMMA;
    CH_COLON:  k = ont_pkg::KIND_COLON;
    default:   punct_kind = 1'b0;
  endcase
endfunction

function automatic bit is_space(input logic [7:0] c);
  return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR;
endfunction

function automatic bit ends_ident(input logic [7:0] c);
  ont_pkg::kind_e k;
  return punct_kind(c, k) || c == CH_DQ || c == CH_SQ || is_space(c) || c == CH_NUL;
endfunction

class token_scoreboard;
  localparam int W = ont_pkg::COUNTER_BITS;

  scan_e          mode;
  bit             single_quote;
  logic [W-1:0]   byte_pos;
  logic [W-1:0]   line;
  logic [W-1:0]   col;
  logic [W-1:0]   beg_off;
  logic [W-1:0]   beg_line;
  logic [W-1:0]   beg_col;
  ont_pkg::token_t word_tokens[$];
  due_token_t     tokens_due[$];
  int unsigned    fail_count;

  function new();
    fail_count = 0;
    reset_scan();
  endfunction

  function void reset_scan();
    mode = SCAN_IDLE;
    single_quote = 1'b0;
    byte_pos = '0;
    line = 1;
    col = 1;
    beg_off = '0;
    beg_line = 1;
    beg_col = 1;
  endfunction

  function logic [W-1:0] sat_inc(logic [W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function void add_token(ont_pkg::kind_e kind, logic [W-1:0] off, logic [W-1:0] len,
                          logic [W-1:0] ln, logic [W-1:0] cl, ont_pkg::err_e err);
    ont_pkg::token_t t;
    t.kind = kind;
    t.offset = off;
    t.length = len;
    t.line = ln;
    t.column = cl;
    t.err = err;
    if (word_tokens.size() < ont_pkg::MAX_TOKENS) word_tokens.push_back(t);
  endfunction

  function void start_at(logic [W-1:0] off);
    beg_off = off;
    beg_line = line;
    beg_col = col;
  endfunction

  function void idle_byte(logic [7:0] c);
    ont_pkg::kind_e k;
    if (punct_kind(c, k)) begin
      add_token(k, byte_pos, 1, line, col, ont_pkg::ERR_NONE);
    end else if (c == CH_DQ || c == CH_SQ) begin
      mode = SCAN_STR;
      single_quote = (c == CH_SQ);
      start_at(sat_inc(byte_pos));
    end else if (c == CH_NUL) begin
      add_token(ont_pkg::KIND_ERROR, byte_pos, 1, line, col, ont_pkg::ERR_BYTE);
    end else if (c == CH_SLASH) begin
      mode = SCAN_SLASH;
      start_at(byte_pos);
    end else if (!is_space(c)) begin
      mode = SCAN_IDENT;
      start_at(byte_pos);
    end
  endfunction

  function void note_word(logic [7:0] c, logic fin);
    due_token_t d;
    word_tokens.delete();
    if (mode == SCAN_SLASH && c == CH_STAR) begin
      mode = SCAN_CMT;
    end else begin
      if (mode == SCAN_SLASH) mode = SCAN_IDENT;
      case (mode)
        SCAN_IDENT: begin
          if (ends_ident(c)) begin
            add_token(ont_pkg::KIND_IDENT, beg_off, byte_pos - beg_off, beg_line, beg_col,
                      ont_pkg::ERR_NONE);
            mode = SCAN_IDLE;
            idle_byte(c);
          end
        end
        SCAN_STR: begin
          if (c == (single_quote ? CH_SQ : CH_DQ)) begin
            add_token(ont_pkg::KIND_STRING, beg_off, byte_pos - beg_off, beg_line, beg_col,
                      ont_pkg::ERR_NONE);
            mode = SCAN_IDLE;
          end else if (c == CH_BSLASH) begin
            mode = SCAN_ESC;
          end
        end
        SCAN_ESC: mode = SCAN_STR;
        SCAN_CMT: begin
          if (c == CH_STAR) mode = SCAN_STAR;
        end
        SCAN_STAR: begin
          if (c == CH_SLASH) mode = SCAN_IDLE;
          else if (c != CH_STAR) mode = SCAN_CMT;
        end
        default: begin
          mode = SCAN_IDLE;
          idle_byte(c);
        end
      endcase
    end

    byte_pos = sat_inc(byte_pos);
    if (c == CH_LF) begin
      line = sat_inc(line);
      col = 1;
    end else begin
      col = sat_inc(col);
    end

    if (fin) begin
      if (mode == SCAN_STR || mode == SCAN_ESC) begin
        add_token(ont_pkg::KIND_ERROR, beg_off, 0, beg_line, beg_col, ont_pkg::ERR_STRING);
      end else if (mode == SCAN_CMT || mode == SCAN_STAR) begin
        add_token(ont_pkg::KIND_ERROR, beg_off, 0, beg_line, beg_col, ont_pkg::ERR_COMMENT);
      end else begin
        if (mode == SCAN_IDENT || mode == SCAN_SLASH) begin
          add_token(ont_pkg::KIND_IDENT, beg_off, byte_pos - beg_off, beg_line, beg_col,
                    ont_pkg::ERR_NONE);
        end
        add_token(ont_pkg::KIND_END, byte_pos, 0, line, col, ont_pkg::ERR_NONE);
      end
      reset_scan();
    end

    foreach (word_tokens[i]) begin
      d.tok = word_tokens[i];
      d.last = (i == word_tokens.size() - 1);
      tokens_due.push_back(d);
    end
  endfunction

  function void check_token(ont_pkg::token_t got, logic got_last);
    due_token_t d;
    if (tokens_due.size() == 0) begin
      $error("unexpected token: token_kind %0d start_offset %0d", got.kind, got.offset);
      fail_count++;
      return;
    end
    d = tokens_due.pop_front();
    if (got.kind !== d.tok.kind) begin
      $error("token_kind: expected %0d, actual %0d", d.tok.kind, got.kind);
      fail_count++;
    end
    if (got.offset !== d.tok.offset) begin
      $error("start_offset: expected %0d, actual %0d", d.tok.offset, got.offset);
      fail_count++;
    end
    if (got.length !== d.tok.length) begin
      $error("token_length: expected %0d, actual %0d", d.tok.length, got.length);
      fail_count++;
    end
    if (got.line !== d.tok.line) begin
      $error("start_line: expected %0d, actual %0d", d.tok.line, got.line);
      fail_count++;
    end
    if (got.column !== d.tok.column) begin
      $error("start_column: expected %0d, actual %0d", d.tok.column, got.column);
      fail_count++;
    end
    if (got.err !== d.tok.err) begin
      $error("error_code: expected %0d, actual %0d", d.tok.err, got.err);
      fail_count++;
    end
    if (got_last !== d.last) begin
      $error("run_end: expected %0d, actual %0d", d.last, got_last);
      fail_count++;
    end
  endfunction

  function int pending();
    return tokens_due.size();
  endfunction
endclass

module tb_top;

  localparam int RANDOM_WORDS = 150;
  localparam int HOLD_CYCLES  = 80;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  text_byte = 8'h00;
  logic        final_byte = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [3:0]  token_kind;
  logic [ont_pkg::FIELD_W-1:0] start_offset;
  logic [ont_pkg::FIELD_W-1:0] token_length;
  logic [ont_pkg::FIELD_W-1:0] start_line;
  logic [ont_pkg::FIELD_W-1:0] start_column;
  logic [1:0]  error_code;
  logic        run_end;

  token_scoreboard sb = new();
  int unsigned words_sent = 0;
  int unsigned burst_left = 0;
  logic [7:0]  text_q[$];

  object_notation_tokenizer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .text_byte_i   (text_byte),
    .final_byte_i  (final_byte),
    .empty         (empty),
    .pop           (pop),
    .token_kind_o  (token_kind),
    .start_offset_o(start_offset),
    .token_length_o(token_length),
    .start_line_o  (start_line),
    .start_column_o(start_column),
    .error_code_o  (error_code),
    .run_end_o     (run_end)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // one word per call, sender bursts and gaps
  task automatic send_word(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        push <= 1'b0;
        @(negedge clk_i);
      end
    end
    burst_left--;
    push <= 1'b1;
    text_byte <= b;
    final_byte <= fin;
    do @(posedge clk_i); while (full);
    sb.note_word(b, fin);
    words_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] ident_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (ends_ident(c)) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] punct_byte();
    logic [7:0] p[8];
    p = '{CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE, CH_COMMA,
          CH_COLON};
    return p[$urandom_range(0, 7)];
  endfunction

  function automatic void build_text();
    int pieces;
    int pick;
    int n;
    logic [7:0] q;
    logic [7:0] c;
    logic [7:0] ws[4];
    ws = '{CH_SP, CH_TAB, CH_CR, CH_LF};
    text_q.delete();
    pieces = $urandom_range(0, 8);
    repeat (pieces) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        text_q.push_back(punct_byte());
      end else if (pick < 45) begin
        n = $urandom_range(1, 6);
        repeat (n) text_q.push_back(ident_byte());
      end else if (pick < 65) begin
        q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
        text_q.push_back(q);
        n = $urandom_range(0, 6);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back(8'($urandom_range(0, 255)));
          end else begin
            c = 8'($urandom_range(0, 255));
            if (c == q || c == CH_BSLASH) c = "a";
            text_q.push_back(c);
          end
        end
        if ($urandom_range(0, 9) != 0) text_q.push_back(q);
      end else if (pick < 80) begin
        n = $urandom_range(1, 3);
        repeat (n) text_q.push_back(ws[$urandom_range(0, 3)]);
      end else if (pick < 90) begin
        text_q.push_back(CH_SLASH);
        text_q.push_back(CH_STAR);
        n = $urandom_range(0, 5);
        repeat (n) begin
          text_q.push_back($urandom_range(0, 1) ? CH_STAR : 8'($urandom_range(0, 255)));
        end
        text_q.push_back(CH_STAR);
        text_q.push_back(CH_SLASH);
      end else if (pick < 95) begin
        text_q.push_back(CH_NUL);
      end else begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    if (text_q.size() > 1 && $urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, text_q.size() - 1);
      while (text_q.size() > n) void'(text_q.pop_back());
    end
    if (text_q.size() == 0) text_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // receiver: stall rate changes by phase, one long hold-off once 60 words are sent
  initial begin
    int stall_pct;
    int phase_left;
    int hold_left;
    bit held;
    stall_pct = 0;
    phase_left = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (phase_left == 0) begin
        phase_left = 40;
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      phase_left--;
      if (!held && words_sent >= 60) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    ont_pkg::token_t got;
    if (rst_ni && pop && !empty) begin
      got.kind = ont_pkg::kind_e'(token_kind);
      got.offset = start_offset;
      got.length = token_length;
      got.line = start_line;
      got.column = start_column;
      got.err = ont_pkg::err_e'(error_code);
      sb.check_token(got, run_end);
    end
  end

  initial begin
    int unsigned random_words;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // punctuation, bad byte, identifier ended by newline
    send_word(CH_LPAREN, 1'b0);
    send_word(CH_LBRACK, 1'b0);
    send_word(CH_LBRACE, 1'b0);
    send_word(CH_RBRACE, 1'b0);
    send_word(CH_RBRACK, 1'b0);
    send_word(CH_RPAREN, 1'b0);
    send_word(CH_COMMA, 1'b0);
    send_word(CH_COLON, 1'b0);
    send_word(CH_NUL, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(CH_LF, 1'b0);
    // string with escaped quote
    send_word(CH_DQ, 1'b0);
    send_word(CH_BSLASH, 1'b0);
    send_word(CH_DQ, 1'b0);
    send_word(CH_DQ, 1'b0);
    // comment closed after a double star
    send_word(CH_SLASH, 1'b0);
    send_word(CH_STAR, 1'b0);
    send_word(CH_STAR, 1'b0);
    send_word(CH_SLASH, 1'b0);
    // slash starting an identifier, ended by comma on the final word
    send_word(CH_SLASH, 1'b0);
    send_word("q", 1'b0);
    send_word(CH_COMMA, 1'b1);
    // unclosed string, unclosed comment
    send_word(CH_SQ, 1'b1);
    send_word(CH_SLASH, 1'b0);
    send_word(CH_STAR, 1'b1);

    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      build_text();
      foreach (text_q[i]) send_word(text_q[i], i == text_q.size() - 1);
      random_words += text_q.size();
    end
    push <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
